@@ sv/bdph_pkg.sv @@
package bdph_pkg;

   localparam int ID_W   = 4;
   localparam int TIME_W = 32;
   localparam int KIND_W = 2;
   localparam int CFG_W  = 16;
   localparam int APB_W  = 32;
   localparam int ADDR_W = 3;

   localparam logic [CFG_W-1:0] DEBOUNCE_RESET = 16'd50;
   localparam logic [CFG_W-1:0] HOLD_RESET     = 16'd1000;

   // Register index, taken from the word-aligned APB address.
   typedef enum logic {
      REG_DEBOUNCE = 1'b0,
      REG_HOLD     = 1'b1
   } reg_index_type;

   typedef enum logic [KIND_W-1:0] {
      KIND_PRESSED  = 2'd0,
      KIND_RELEASED = 2'd1,
      KIND_HELD     = 2'd2
   } event_kind_type;

   typedef struct packed {
      logic              last_reading;
      logic              debounced_pressed;
      logic              held_flag;
      logic [TIME_W-1:0] change_time;
      logic [TIME_W-1:0] press_time;
   } btn_entry_type;

endpackage

@@ sv/bdph_sample_if.sv @@
interface bdph_sample_if
   import bdph_pkg::*;
   ;
   logic              valid;
   logic              ready;
   logic [ID_W-1:0]   button_id;
   logic              pin_level;
   logic [TIME_W-1:0] now_ms;

   modport source (output valid, button_id, pin_level, now_ms, input ready);
   modport sink (input valid, button_id, pin_level, now_ms, output ready);
endinterface

@@ sv/bdph_event_if.sv @@
interface bdph_event_if
   import bdph_pkg::*;
   ;
   logic              valid;
   logic              ready;
   logic [ID_W-1:0]   event_button;
   logic [KIND_W-1:0] event_kind;
   logic [TIME_W-1:0] event_time;

   modport source (output valid, event_button, event_kind, event_time, input ready);
   modport sink (input valid, event_button, event_kind, event_time, output ready);
endinterface

@@ sv/bdph_state_mem.sv @@
module bdph_state_mem
   import bdph_pkg::*;
#(
   parameter int NUM_BUTTONS = 16,
   parameter int AW          = 4
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          rd_en,
   input  logic [AW-1:0] rd_addr,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  btn_entry_type wr_data,
   output btn_entry_type rd_data
);

   btn_entry_type mem [NUM_BUTTONS];
   btn_entry_type mem_q_ff;
   logic [NUM_BUTTONS-1:0] valid_ff;
   logic          rvalid_ff;
   logic [AW-1:0] raddr_ff;
   logic          last_wr_valid_ff;
   logic [AW-1:0] last_wr_addr_ff;
   btn_entry_type last_wr_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         mem_q_ff <= mem[rd_addr];
         raddr_ff <= rd_addr;
      end
      if (wr_en) begin
         last_wr_addr_ff <= wr_addr;
         last_wr_data_ff <= wr_data;
      end
   end

   // Entries never written read as the reset state through their valid bits.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff         <= '0;
         rvalid_ff        <= 1'b0;
         last_wr_valid_ff <= 1'b0;
      end else begin
         if (wr_en) begin
            valid_ff[wr_addr] <= 1'b1;
            last_wr_valid_ff  <= 1'b1;
         end
         if (rd_en) begin
            rvalid_ff <= valid_ff[rd_addr];
         end
      end
   end

   // A write landing on the same edge as the read is not seen by the array
   // output, so the most recent write is forwarded when the addresses match.
   always_comb begin
      if (last_wr_valid_ff && (last_wr_addr_ff == raddr_ff)) begin
         rd_data = last_wr_data_ff;
      end else if (rvalid_ff) begin
         rd_data = mem_q_ff;
      end else begin
         rd_data = '0;
      end
   end

endmodule

@@ sv/button_debounce_press_release_hold.sv @@
// Debounces up to NUM_BUTTONS active-low buttons that are sampled one word at a
// time, and reports pressed, released and held (long-press) events. Per-button
// state sits in a single memory with a registered read; a sample is accepted
// every cycle, its entry is read on the accepting edge, updated in the following
// cycle and written back, with the latest write forwarded when consecutive
// samples hit the same button. Events enter the output register when the update
// stage passes the sample on; a sample stalls only while that register holds an
// event that has not been taken. Sample indices at or above NUM_BUTTONS
// are dropped without effect. The debounce and hold times are programmed through
// the APB port at byte addresses 0 and 4 and read back zero-extended.
module button_debounce_press_release_hold
   import bdph_pkg::*;
#(
   parameter int NUM_BUTTONS = 16
) (
   input  logic              clock,
   input  logic              reset,
   bdph_sample_if.sink       req,
   bdph_event_if.source      rsp,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [ADDR_W-1:0] paddr,
   input  logic [APB_W-1:0]  pwdata,
   output logic [APB_W-1:0]  prdata,
   output logic              pready
);

   localparam int AW = (NUM_BUTTONS > 1) ? $clog2(NUM_BUTTONS) : 1;

   // Configuration registers
   logic [CFG_W-1:0] debounce_ff;
   logic [CFG_W-1:0] hold_ff;
   logic             csr_write;
   reg_index_type    csr_index;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite;
   assign csr_index = reg_index_type'(paddr[2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         debounce_ff <= DEBOUNCE_RESET;
         hold_ff     <= HOLD_RESET;
      end else if (csr_write) begin
         unique case (csr_index)
            REG_DEBOUNCE: debounce_ff <= pwdata[CFG_W-1:0];
            REG_HOLD:     hold_ff     <= pwdata[CFG_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_index)
         REG_DEBOUNCE: prdata = APB_W'(debounce_ff);
         REG_HOLD:     prdata = APB_W'(hold_ff);
         default:      prdata = '0;
      endcase
   end

   // Input decode
   logic [31:0]   id_wide;
   logic          req_in_range;
   logic          req_accept;
   logic [AW-1:0] req_addr;

   assign id_wide      = 32'(req.button_id);
   assign req_in_range = id_wide < 32'(NUM_BUTTONS);
   assign req_addr     = id_wide[AW-1:0];
   assign req_accept   = req.valid && req.ready;

   // Update stage
   logic              s1_valid_ff;
   logic              s1_in_range_ff;
   logic [AW-1:0]     s1_addr_ff;
   logic [ID_W-1:0]   s1_id_ff;
   logic              s1_reading_ff;
   logic [TIME_W-1:0] s1_now_ff;
   logic              s1_adv;
   btn_entry_type     s1_entry;
   btn_entry_type     s1_entry_new;
   logic              s1_event;
   event_kind_type    s1_kind;
   logic [TIME_W-1:0] s1_change_time;
   logic [TIME_W-1:0] since_change;
   logic [TIME_W-1:0] since_press;
   logic              debounce_done;

   logic              rsp_valid_ff;
   logic              rsp_valid_in;
   logic [ID_W-1:0]   rsp_button_ff;
   event_kind_type    rsp_kind_ff;
   logic [TIME_W-1:0] rsp_time_ff;

   assign s1_adv    = s1_valid_ff && (!rsp_valid_ff || rsp.ready);
   assign req.ready = !s1_valid_ff || s1_adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req.ready) begin
         s1_valid_ff <= req.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_in_range_ff <= req_in_range;
         s1_addr_ff     <= req_addr;
         s1_id_ff       <= req.button_id;
         s1_reading_ff  <= !req.pin_level;
         s1_now_ff      <= req.now_ms;
      end
   end

   bdph_state_mem #(
      .NUM_BUTTONS (NUM_BUTTONS),
      .AW          (AW)
   ) u_state_mem (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (req_accept && req_in_range),
      .rd_addr (req_addr),
      .wr_en   (s1_adv && s1_in_range_ff),
      .wr_addr (s1_addr_ff),
      .wr_data (s1_entry_new),
      .rd_data (s1_entry)
   );

   assign s1_change_time = (s1_reading_ff != s1_entry.last_reading) ? s1_now_ff
                                                                   : s1_entry.change_time;
   assign since_change   = s1_now_ff - s1_change_time;
   assign since_press    = s1_now_ff - s1_entry.press_time;
   assign debounce_done  = (since_change > TIME_W'(debounce_ff)) &&
                           (s1_reading_ff != s1_entry.debounced_pressed);

   always_comb begin
      s1_entry_new              = s1_entry;
      s1_entry_new.last_reading = s1_reading_ff;
      s1_entry_new.change_time  = s1_change_time;
      s1_event                  = 1'b0;
      s1_kind                   = KIND_PRESSED;
      if (debounce_done) begin
         s1_entry_new.debounced_pressed = s1_reading_ff;
         s1_event                       = 1'b1;
         if (s1_reading_ff) begin
            s1_entry_new.press_time = s1_now_ff;
            s1_kind                 = KIND_PRESSED;
         end else begin
            s1_entry_new.held_flag = 1'b0;
            s1_kind                = KIND_RELEASED;
         end
      end else if (s1_entry.debounced_pressed && !s1_entry.held_flag &&
                   (since_press > TIME_W'(hold_ff))) begin
         s1_entry_new.held_flag = 1'b1;
         s1_event               = 1'b1;
         s1_kind                = KIND_HELD;
      end
      if (!s1_in_range_ff) begin
         s1_event = 1'b0;
      end
   end

   // Output register
   always_comb begin
      if (s1_adv) begin
         rsp_valid_in = s1_event;
      end else if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_adv && s1_event) begin
         rsp_button_ff <= s1_id_ff;
         rsp_kind_ff   <= s1_kind;
         rsp_time_ff   <= s1_now_ff;
      end
   end

   assign rsp.valid        = rsp_valid_ff;
   assign rsp.event_button = rsp_button_ff;
   assign rsp.event_kind   = rsp_kind_ff;
   assign rsp.event_time   = rsp_time_ff;

   // A held word is only produced for a button that stays pressed and is now marked held.
   a_held_state: assert property (@(posedge clock) disable iff (reset)
      (s1_event && s1_kind == KIND_HELD) |->
         (s1_entry_new.debounced_pressed && s1_entry_new.held_flag))
      else $error("held event without pressed and held state");

   // A release always leaves the button unpressed with the held mark cleared.
   a_release_state: assert property (@(posedge clock) disable iff (reset)
      (s1_event && s1_kind == KIND_RELEASED) |->
         (!s1_entry_new.debounced_pressed && !s1_entry_new.held_flag))
      else $error("release event left stale state");

   // A press records its own time as the press time.
   a_press_time: assert property (@(posedge clock) disable iff (reset)
      (s1_event && s1_kind == KIND_PRESSED) |->
         (s1_entry_new.debounced_pressed && s1_entry_new.press_time == s1_now_ff))
      else $error("press event with wrong press time");

   // An event leaving the update stage must be in the output register on the next edge.
   a_event_lands: assert property (@(posedge clock) disable iff (reset)
      (s1_adv && s1_event) |=>
         (rsp_valid_ff && rsp_time_ff == $past(s1_now_ff)))
      else $error("event lost between update stage and output register");

endmodule

@@ bench/button_debounce_press_release_hold_tb.sv @@
module button_debounce_press_release_hold_tb
   import bdph_pkg::*;
   ;

   localparam int BUTTONS     = 16;
   localparam int PHASES      = 9;
   localparam int PHASE_WORDS = 140;
   localparam int SETTLE      = 6;
   localparam int DRAIN_LIMIT = 4000;
   localparam int LIMIT       = 400000;

   typedef struct packed {
      logic [ID_W-1:0]   button;
      event_kind_type    kind;
      logic [TIME_W-1:0] at;
   } button_event_type;

   // Tracks the debouncer state of every button and queues the events it should report.
   class event_board;
      logic [CFG_W-1:0]  debounce_ms;
      logic [CFG_W-1:0]  hold_ms;
      bit                last_reading [BUTTONS];
      bit                pressed [BUTTONS];
      bit                held [BUTTONS];
      bit [TIME_W-1:0]   change_time [BUTTONS];
      bit [TIME_W-1:0]   press_time [BUTTONS];
      button_event_type  pending [$];
      int                errors;

      function new();
         debounce_ms = DEBOUNCE_RESET;
         hold_ms     = HOLD_RESET;
         errors      = 0;
      endfunction

      function void report(string what);
         $display("ERROR: %s", what);
         errors++;
      endfunction

      function void set_register(reg_index_type idx, logic [APB_W-1:0] value);
         case (idx)
            REG_DEBOUNCE: debounce_ms = value[CFG_W-1:0];
            REG_HOLD:     hold_ms = value[CFG_W-1:0];
            default:      ;
         endcase
      endfunction

      function void note_sample(logic [ID_W-1:0] id, logic pin, logic [TIME_W-1:0] at);
         bit               down;
         bit               fired;
         button_event_type ev;
         if (int'(id) >= BUTTONS) return;
         // The pin is pulled up, so a low level means the button is down.
         down  = ~pin;
         fired = 1'b0;
         ev.button = id;
         ev.at     = at;
         if (down != last_reading[id]) change_time[id] = at;
         if ((at - change_time[id]) > TIME_W'(debounce_ms) && down != pressed[id]) begin
            pressed[id] = down;
            if (down) begin
               press_time[id] = at;
               ev.kind = KIND_PRESSED;
            end else begin
               held[id] = 1'b0;
               ev.kind  = KIND_RELEASED;
            end
            fired = 1'b1;
         end
         if (!fired && pressed[id] && !held[id] &&
             (at - press_time[id]) > TIME_W'(hold_ms)) begin
            held[id] = 1'b1;
            ev.kind  = KIND_HELD;
            fired    = 1'b1;
         end
         last_reading[id] = down;
         if (fired) pending.push_back(ev);
      endfunction

      function void check_event(logic [ID_W-1:0] b, logic [KIND_W-1:0] k,
                                logic [TIME_W-1:0] t);
         button_event_type want;
         if (pending.size() == 0) begin
            report($sformatf("unexpected event: button %0d kind %0d time %0d", b, k, t));
            return;
         end
         want = pending.pop_front();
         if (b !== want.button)
            report($sformatf("event_button %0d, wanted %0d", b, want.button));
         if (k !== want.kind)
            report($sformatf("event_kind %0d, wanted %s (button %0d)", k, want.kind.name(),
                             want.button));
         if (t !== want.at)
            report($sformatf("event_time %0d, wanted %0d (button %0d)", t, want.at,
                             want.button));
      endfunction
   endclass

   logic              clock = 1'b0;
   logic              reset;
   logic              psel;
   logic              penable;
   logic              pwrite;
   logic [ADDR_W-1:0] paddr;
   logic [APB_W-1:0]  pwdata;
   logic [APB_W-1:0]  prdata;
   logic              pready;
   bit                calm;
   int unsigned       cycles;
   logic [TIME_W-1:0] wall_ms;
   event_board        board;

   bdph_sample_if req_if ();
   bdph_event_if  rsp_if ();

   button_debounce_press_release_hold u_dut (
      .clock   (clock),
      .reset   (reset),
      .req     (req_if),
      .rsp     (rsp_if),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   always #10 clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == LIMIT) begin
         $display("button_debounce_press_release_hold: mismatch");
         $finish;
      end
   end

   task automatic write_register(reg_index_type idx, logic [APB_W-1:0] value);
      @(posedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= ADDR_W'({idx, 2'b00});
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      board.set_register(idx, value);
   endtask

   task automatic send_sample(logic [ID_W-1:0] id, logic pin, logic [TIME_W-1:0] at);
      int gap;
      if (!calm && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 12);
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.valid     <= 1'b1;
      req_if.button_id <= id;
      req_if.pin_level <= pin;
      req_if.now_ms    <= at;
      do @(posedge clock); while (!req_if.ready);
      board.note_sample(id, pin, at);
   endtask

   // Steps are sized against the current settings so that the debounce and hold
   // boundaries are hit exactly as well as crossed.
   function automatic logic [TIME_W-1:0] time_step(logic [CFG_W-1:0] dbn,
                                                    logic [CFG_W-1:0] hld);
      case ($urandom_range(0, 9))
         0:       return 0;
         1:       return 1;
         2:       return $urandom_range(0, dbn);
         3:       return TIME_W'(dbn);
         4:       return TIME_W'(dbn) + 1;
         5:       return TIME_W'(hld / 4) + $urandom_range(0, 3);
         6:       return TIME_W'(hld);
         7:       return TIME_W'(hld) + 1;
         8:       return $urandom_range(0, 3 * int'(hld) + 3);
         default: return $urandom_range(0, 1) ? $urandom : $urandom_range(0, 15);
      endcase
   endfunction

   // Mostly one button at a time, held at an intended level with occasional
   // bounces, interleaved with random samples of the other buttons.
   task automatic run_random(int words);
      logic [ID_W-1:0]    id;
      logic [ID_W-1:0]    focus;
      logic               pin;
      logic [BUTTONS-1:0] intent;
      intent = '1;
      focus  = ID_W'($urandom_range(0, BUTTONS - 1));
      for (int n = 0; n < words; n++) begin
         if ($urandom_range(0, 19) == 0) focus = ID_W'($urandom_range(0, BUTTONS - 1));
         if ($urandom_range(0, 11) == 0) intent[focus] = ~intent[focus];
         if ($urandom_range(0, 9) < 7) begin
            id  = focus;
            pin = ($urandom_range(0, 6) == 0) ? ~intent[id] : intent[id];
         end else begin
            id  = ID_W'($urandom_range(0, BUTTONS - 1));
            pin = 1'($urandom_range(0, 1));
         end
         wall_ms = wall_ms + time_step(board.debounce_ms, board.hold_ms);
         send_sample(id, pin, wall_ms);
      end
   endtask

   task automatic drain_events();
      int waited;
      waited = 0;
      req_if.valid <= 1'b0;
      while (board.pending.size() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      repeat (SETTLE) @(posedge clock);
      if (board.pending.size() != 0) begin
         board.report($sformatf("%0d events never arrived", board.pending.size()));
         board.pending.delete();
      end
   endtask

   initial begin
      int               stall;
      stall = 0;
      rsp_if.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_if.valid && rsp_if.ready)
            board.check_event(rsp_if.event_button, rsp_if.event_kind, rsp_if.event_time);
         if (stall > 0) begin
            stall--;
            rsp_if.ready <= 1'b0;
         end else if (!calm && $urandom_range(0, 7) == 0) begin
            stall = $urandom_range(0, 11);
            rsp_if.ready <= 1'b0;
         end else begin
            rsp_if.ready <= 1'b1;
         end
      end
   end

   initial begin
      logic [CFG_W-1:0] dbn;
      logic [CFG_W-1:0] hld;
      board = new();
      calm  = 1'b0;
      cycles = 0;
      wall_ms = 0;
      reset            <= 1'b1;
      req_if.valid     <= 1'b0;
      req_if.button_id <= '0;
      req_if.pin_level <= 1'b1;
      req_if.now_ms    <= '0;
      psel             <= 1'b0;
      penable          <= 1'b0;
      pwrite           <= 1'b0;
      paddr            <= '0;
      pwdata           <= '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed words at the reset settings: boundaries, bounces, hold,
      // time wrap and time running backwards.
      send_sample(4'd0, 1'b1, 32'd0);
      send_sample(4'd0, 1'b0, 32'd100);
      send_sample(4'd0, 1'b0, 32'd150);
      send_sample(4'd0, 1'b0, 32'd151);
      send_sample(4'd0, 1'b1, 32'd160);
      send_sample(4'd0, 1'b0, 32'd170);
      send_sample(4'd0, 1'b0, 32'd1151);
      send_sample(4'd0, 1'b0, 32'd1152);
      send_sample(4'd0, 1'b0, 32'd5000);
      send_sample(4'd0, 1'b1, 32'd5001);
      send_sample(4'd0, 1'b1, 32'd5052);
      send_sample(4'd15, 1'b0, 32'hFFFF_FFF0);
      send_sample(4'd15, 1'b0, 32'h0000_0022);
      send_sample(4'd15, 1'b0, 32'h0000_0023);
      send_sample(4'd15, 1'b0, 32'hFFFF_FFFF);
      send_sample(4'd7, 1'b0, 32'h5555_5555);
      send_sample(4'd7, 1'b1, 32'hAAAA_AAAA);
      send_sample(4'd8, 1'b0, 32'hAAAA_AAAA);
      send_sample(4'd8, 1'b0, 32'h0000_0000);
      send_sample(4'd15, 1'b1, 32'h0000_1000);
      send_sample(4'd15, 1'b1, 32'h0000_1033);
      drain_events();

      for (int phase = 0; phase < PHASES; phase++) begin
         case (phase)
            0:       begin dbn = 16'd0;      hld = 16'd0;      end
            1:       begin dbn = 16'hFFFF;   hld = 16'hFFFF;   end
            2:       begin dbn = 16'd0;      hld = 16'hFFFF;   end
            3:       begin dbn = 16'hFFFF;   hld = 16'd0;      end
            4:       begin dbn = 16'd3;      hld = 16'd10;     end
            default: begin
               dbn = CFG_W'($urandom_range(0, 200));
               hld = CFG_W'($urandom_range(0, 3000));
            end
         endcase
         calm = (phase == PHASES - 1);
         // The upper half of the write data must be ignored by the block.
         if ($urandom_range(0, 1)) begin
            write_register(REG_DEBOUNCE, {16'($urandom), dbn});
            write_register(REG_HOLD, {16'($urandom), hld});
         end else begin
            write_register(REG_HOLD, {16'($urandom), hld});
            write_register(REG_DEBOUNCE, {16'($urandom), dbn});
         end
         run_random(PHASE_WORDS);
         drain_events();
      end

      if (board.errors == 0)
         $display("button_debounce_press_release_hold: match");
      else
         $display("button_debounce_press_release_hold: mismatch");
      $finish;
   end

endmodule
